>>> rtl/mxt_pkg.sv
// Shared constants and types for the maximum XOR pair trie block.
package mxt_pkg;

  localparam int VALUE_BITS = 32;
  localparam int NODE_COUNT = 4096;
  localparam int NODE_AW    = $clog2(NODE_COUNT);
  localparam int CNT_W      = NODE_AW + 1;
  localparam int LVL_W      = $clog2(VALUE_BITS);
  localparam int LINK_W     = 2 * NODE_AW;

  typedef logic [NODE_AW-1:0]         node_t;
  typedef logic [1:0][NODE_AW-1:0]    links_t;
  typedef logic [VALUE_BITS-1:0]      value_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WALK  = 5'b00010,
    ST_INS   = 5'b00100,
    ST_QWALK = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

>>> rtl/mxt_if.sv
// Valid/ready channel interfaces for the input and result words.
interface mxt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_in;
  logic        last_value;

  modport source (output valid, output value_in, output last_value, input ready);
  modport sink   (input valid, input value_in, input last_value, output ready);
endinterface

interface mxt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pair_xor;
  logic [31:0] running_max;
  logic        store_full;

  modport source (output valid, output pair_xor, output running_max, output store_full,
                  input ready);
  modport sink   (input valid, input pair_xor, input running_max, input store_full,
                  output ready);
endinterface

>>> rtl/mxt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/max_xor_pair_trie_top.sv
// Top level of the maximum XOR pair trie: sequencer, root links and node memory.
//
//   channel  dir  fields                                  word accepted when
//   in_ch    in   value_in[31:0], last_value              valid && ready
//   out_ch   out  pair_xor[31:0], running_max[31:0],      valid && ready
//                 store_full
//
// The insert walk, the allocation writes and the greedy query each touch one trie
// level per cycle, as the single node memory allows; a result then waits in the
// done state while the output register is still held by a stalled result.
// A synchronous reset empties the root, sets the node count to the root alone
// and clears the running maximum; the node memory itself needs no clearing pass.
// A result waits in an output register, so the next word is accepted while the
// previous result is still stalled downstream.
module max_xor_pair_trie_top
  import mxt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  mxt_in_if.sink          in_ch,
  mxt_out_if.source       out_ch
);

  // Sequencer state. The root's links live in flip-flops so that a clear needs no
  // pass over memory; every other node lives in the node memory.
  state_t            state;
  links_t            root_links;
  logic [CNT_W-1:0]  nodes_used;
  logic [31:0]       best;

  // Per-word working registers.
  value_t            val;
  logic              last_r;
  logic [LVL_W-1:0]  lvl;
  logic              on_root;
  node_t             cur_node;
  logic              par_root;
  node_t             par_node;
  links_t            par_links;
  logic              ins_parent;
  logic              full_r;
  value_t            acc;

  // Output register.
  logic              out_valid;
  logic [31:0]       out_pair;
  logic [31:0]       out_max;
  logic              out_full;

  // Node memory port.
  logic              ram_we;
  node_t             ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  node_t             ram_raddr;
  logic [LINK_W-1:0] ram_rdata;

  // The links of the node the walk is standing on: either the root register or
  // the word read from memory in the previous cycle.
  links_t            cur_links;
  logic              bit_cur;
  logic              bit_dn;
  logic [LVL_W-1:0]  lvl_dn;
  node_t             child;
  node_t             q_next;
  logic              q_take_alt;
  logic [LVL_W:0]    needed;
  logic [CNT_W+1:0]  need_sum;
  logic              no_room;
  links_t            par_new;
  links_t            fresh_links;
  node_t             fresh_idx;
  logic              out_free;
  logic [31:0]       new_max;

  assign cur_links  = on_root ? root_links : links_t'(ram_rdata);
  assign bit_cur    = val[lvl];
  assign lvl_dn     = lvl - 1'b1;
  assign bit_dn     = val[lvl_dn];
  assign child      = cur_links[bit_cur];
  assign q_take_alt = (cur_links[~bit_cur] != '0);
  assign q_next     = q_take_alt ? cur_links[~bit_cur] : cur_links[bit_cur];

  // Nodes this insert still needs when the walk misses at the current level.
  assign needed     = {1'b0, lvl} + 1'b1;
  assign need_sum   = {1'b0, {1'b0, nodes_used}} + (CNT_W+2)'(needed);
  assign no_room    = (need_sum > (CNT_W+2)'(NODE_COUNT));

  // Fresh nodes take consecutive indices; each but the last links straight to the next.
  assign fresh_idx  = nodes_used[NODE_AW-1:0];

  always_comb begin
    par_new = par_links;
    par_new[bit_cur] = fresh_idx;
    fresh_links = '0;
    if (lvl != '0) begin
      fresh_links[bit_dn] = fresh_idx + node_t'(1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fresh_idx;
    ram_wdata = LINK_W'(fresh_links);
    ram_raddr = '0;
    unique case (state)
      ST_WALK:  ram_raddr = child;
      ST_QWALK: ram_raddr = q_next;
      ST_INS: begin
        if (ins_parent) begin
          ram_we    = !par_root;
          ram_waddr = par_node;
          ram_wdata = LINK_W'(par_new);
        end else begin
          ram_we    = 1'b1;
        end
      end
      default: ram_raddr = '0;
    endcase
  end

  assign out_free = !out_valid || out_ch.ready;
  assign new_max  = (acc > best) ? acc : best;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      root_links <= '0;
      nodes_used <= CNT_W'(1);
      best       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            val      <= in_ch.value_in[VALUE_BITS-1:0];
            last_r   <= in_ch.last_value;
            full_r   <= 1'b0;
            on_root  <= 1'b1;
            cur_node <= '0;
            lvl      <= LVL_W'(VALUE_BITS - 1);
            state    <= ST_WALK;
          end
        end

        // Follow the value's own bits until a link is missing or the leaf level
        // is passed; the level of a miss also gives how many nodes the insert would add.
        ST_WALK: begin
          acc <= '0;
          if (child == '0) begin
            par_root   <= on_root;
            par_node   <= cur_node;
            par_links  <= cur_links;
            ins_parent <= 1'b1;
            if (no_room) begin
              full_r  <= 1'b1;
              on_root <= 1'b1;
              lvl     <= LVL_W'(VALUE_BITS - 1);
              state   <= ST_QWALK;
            end else begin
              state <= ST_INS;
            end
          end else if (lvl == '0) begin
            on_root <= 1'b1;
            lvl     <= LVL_W'(VALUE_BITS - 1);
            state   <= ST_QWALK;
          end else begin
            on_root  <= 1'b0;
            cur_node <= child;
            lvl      <= lvl_dn;
          end
        end

        // First hook the new branch onto the parent, then write one fresh node
        // per remaining level.
        ST_INS: begin
          if (ins_parent) begin
            ins_parent <= 1'b0;
            if (par_root) begin
              root_links <= par_new;
            end
          end else begin
            nodes_used <= nodes_used + 1'b1;
            if (lvl == '0) begin
              on_root <= 1'b1;
              lvl     <= LVL_W'(VALUE_BITS - 1);
              state   <= ST_QWALK;
            end else begin
              lvl <= lvl_dn;
            end
          end
        end

        // Greedy search: prefer the opposite branch at every level.
        ST_QWALK: begin
          if (on_root && (root_links == '0)) begin
            state <= ST_DONE;
          end else begin
            on_root <= 1'b0;
            if (q_take_alt) begin
              acc[lvl] <= 1'b1;
            end
            if (lvl == '0) begin
              state <= ST_DONE;
            end else begin
              lvl <= lvl_dn;
            end
          end
        end

        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (last_r) begin
              root_links <= '0;
              nodes_used <= CNT_W'(1);
              best       <= '0;
            end else begin
              best <= new_max;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: loaded from the done state, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_pair <= 32'(acc);
      out_max  <= new_max;
      out_full <= full_r;
    end
  end

  assign in_ch.ready        = (state == ST_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.pair_xor    = out_pair;
  assign out_ch.running_max = out_max;
  assign out_ch.store_full  = out_full;

  mxt_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The node count always covers the root and never passes the memory size.
  a_nodes_range: assert property (@(posedge clk) disable iff (rst)
    (nodes_used >= CNT_W'(1)) && (nodes_used <= CNT_W'(NODE_COUNT)))
    else $error("node count out of range");

  // The root is kept in flip-flops, so memory entry zero is never written.
  a_no_root_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_waddr != '0))
    else $error("node memory write to root entry");

  // A result never reports a running maximum below its own pair value.
  a_max_order: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.running_max >= out_ch.pair_xor))
    else $error("running maximum below pair value");

  // A finished word is always handed to the output register on the next edge.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && out_free) |=> (out_valid && (state == ST_IDLE)))
    else $error("result not loaded");

endmodule
